// File: rtl/core/ipa_pkg.sv
// ----------------------------------------------------------------------------
// ipa_pkg
// Shared widths, constants and lane/merge types of the address id assigner.
// ----------------------------------------------------------------------------
package ipa_pkg;

  localparam int ADDR_W = 32;
  localparam int SEC_W  = 32;
  localparam int US_W   = 20;
  localparam int ID_W   = 9;

  localparam logic [US_W-1:0] MICROS_MAX     = US_W'(999999);
  localparam logic [US_W:0]   MICROS_PER_SEC = (US_W+1)'(1000000);

  // per-lane compare result for one returned row
  typedef struct packed {
    logic src_hit;
    logic dst_hit;
  } lane_hit_t;

  // accumulated lookup result over the whole scan
  typedef struct packed {
    logic            src_found;
    logic            dst_found;
    logic [ID_W-1:0] src_id;
    logic [ID_W-1:0] dst_id;
  } merge_res_t;

endpackage

// File: rtl/core/ipa_in_if.sv
// ----------------------------------------------------------------------------
// ipa_in_if
// Request channel: one packet's addresses and capture timestamp.
// ----------------------------------------------------------------------------
interface ipa_in_if;
  import ipa_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] source_address;
  logic [ADDR_W-1:0] dest_address;
  logic [SEC_W-1:0]  stamp_seconds;
  logic [US_W-1:0]   stamp_micros;

  modport source (output valid, source_address, dest_address, stamp_seconds,
                  stamp_micros, input ready);
  modport sink   (input valid, source_address, dest_address, stamp_seconds,
                  stamp_micros, output ready);
endinterface

// File: rtl/core/ipa_out_if.sv
// ----------------------------------------------------------------------------
// ipa_out_if
// Result channel: assigned ids, time delta and status flags.
// ----------------------------------------------------------------------------
interface ipa_out_if;
  import ipa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ID_W-1:0]         source_id;
  logic [ID_W-1:0]         dest_id;
  logic signed [SEC_W-1:0] delta_seconds;
  logic [US_W-1:0]         delta_micros;
  logic                    first_packet;
  logic                    table_full;

  modport source (output valid, source_id, dest_id, delta_seconds, delta_micros,
                  first_packet, table_full, input ready);
  modport sink   (input valid, source_id, dest_id, delta_seconds, delta_micros,
                  first_packet, table_full, output ready);
endinterface

// File: rtl/core/ipa_ram.sv
// ----------------------------------------------------------------------------
// ipa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/ipa_lane.sv
// ----------------------------------------------------------------------------
// ipa_lane
// One table bank: holds every LANES-th entry and compares a returned row
// against the request's source and destination addresses.
// ----------------------------------------------------------------------------
module ipa_lane #(
  parameter int RW       = 6,
  parameter int LW       = 2,
  parameter int XW       = 9,
  parameter int LANE_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [RW-1:0]             rd_row,
  input  logic [RW-1:0]             rd_row_d,
  input  logic                      wr_en,
  input  logic [RW-1:0]             wr_row,
  input  logic [ipa_pkg::ADDR_W-1:0] wr_data,
  input  logic [ipa_pkg::ADDR_W-1:0] src_addr,
  input  logic [ipa_pkg::ADDR_W-1:0] dst_addr,
  input  logic [XW-1:0]             count_x,
  output ipa_pkg::lane_hit_t        hit
);
  import ipa_pkg::*;

  logic [ADDR_W-1:0] rd_data;
  logic [RW+LW-1:0]  entry_idx;
  logic              entry_live;

  ipa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (1 << RW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_row),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_row),
    .rd_data (rd_data)
  );

  // only entries below the fill count hold stored addresses
  assign entry_idx  = {rd_row_d, LW'(LANE_IDX)};
  assign entry_live = XW'(entry_idx) < count_x;

  assign hit.src_hit = entry_live && (rd_data == src_addr);
  assign hit.dst_hit = entry_live && (rd_data == dst_addr);

endmodule

// File: rtl/core/ipa_merge.sv
// ----------------------------------------------------------------------------
// ipa_merge
// Combines the lane compare results of each returned row and keeps the
// source and destination ids found so far in the scan.
// ----------------------------------------------------------------------------
module ipa_merge #(
  parameter int LANES = 4,
  parameter int RW    = 6,
  parameter int LW    = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clr,
  input  logic                            row_vld,
  input  logic [RW-1:0]                   row,
  input  ipa_pkg::lane_hit_t [LANES-1:0]  hits,
  output ipa_pkg::merge_res_t             res
);
  import ipa_pkg::*;

  merge_res_t res_r, res_nxt;
  logic            row_src_hit, row_dst_hit;
  logic [ID_W-1:0] row_src_id, row_dst_id;

  // stored addresses are unique, so at most one lane hits per address
  always_comb begin
    row_src_hit = 1'b0;
    row_dst_hit = 1'b0;
    row_src_id  = '0;
    row_dst_id  = '0;
    for (int l = 0; l < LANES; l++) begin
      if (hits[l].src_hit) begin
        row_src_hit = 1'b1;
        row_src_id  = ID_W'({1'b0, row, LW'(l)} + (RW+LW+1)'(1));
      end
      if (hits[l].dst_hit) begin
        row_dst_hit = 1'b1;
        row_dst_id  = ID_W'({1'b0, row, LW'(l)} + (RW+LW+1)'(1));
      end
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (clr) begin
      res_nxt = '0;
    end else if (row_vld) begin
      if (row_src_hit) begin
        res_nxt.src_found = 1'b1;
        res_nxt.src_id    = row_src_id;
      end
      if (row_dst_hit) begin
        res_nxt.dst_found = 1'b1;
        res_nxt.dst_id    = row_dst_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: rtl/core/ip_address_id_assigner_top.sv
// ----------------------------------------------------------------------------
// ip_address_id_assigner_top
// Assigns sequential ids to IPv4 addresses and reports packet time deltas.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  in_req   | in  | valid/ready          | source/dest address, stamp sec/us
//  out_res  | out | valid/ready          | ids, delta sec/us, first, full
//
//  One request in flight: after the accept, the banked scan reads one row of
//  LANES entries per cycle up to the table fill N, then the source and the
//  destination insert states run before the result loads. The next request
//  can be taken from the cycle after a result loads. Both addresses are
//  compared in one scan; reset (synchronous) clears the fill count. A held
//  result stalls only the next result load.
// ----------------------------------------------------------------------------
module ip_address_id_assigner_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int LANES       = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  ipa_in_if.sink   in_req,
  ipa_out_if.source out_res
);
  import ipa_pkg::*;

  localparam int LW   = $clog2(LANES);
  localparam int ROWS = (TABLE_DEPTH + LANES - 1) / LANES;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EW   = RW + LW;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int XW   = (CW > EW) ? CW : EW;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_INS_SRC = 3'd2;
  localparam logic [2:0] S_INS_DST = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [XW-1:0]     count_x, rows_need;
  logic [XW-1:0]     row_r, row_nxt;
  logic              rd_vld_r;
  logic [RW-1:0]     rd_row_r;
  logic              rd_issue;
  logic              accept;

  logic [ADDR_W-1:0] src_r, dst_r;
  logic [SEC_W-1:0]  sec_r, last_sec_r;
  logic [US_W-1:0]   us_r, last_us_r;
  logic              have_last_r;
  logic [ID_W-1:0]   sid_r, sid_nxt, did_r, did_nxt;
  logic              full_r, full_nxt;

  logic              wr_en;
  logic [LANES-1:0]  lane_wr;
  logic [ADDR_W-1:0] wr_data;
  logic              has_room;
  logic [ID_W-1:0]   new_id;

  lane_hit_t [LANES-1:0] hits;
  merge_res_t            mres;

  logic                    out_valid_r;
  logic [ID_W-1:0]         out_sid_r, out_did_r;
  logic signed [SEC_W-1:0] out_dsec_r;
  logic [US_W-1:0]         out_dus_r;
  logic                    out_first_r, out_full_r;

  logic                    borrow;
  logic [SEC_W-1:0]        dsec;
  logic [US_W-1:0]         dus;
  logic                    out_load;

  assign accept       = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);

  // table scan: one row of all lanes per cycle
  assign count_x   = XW'(count_r);
  assign rows_need = (count_x + XW'(LANES - 1)) >> LW;
  assign rd_issue  = (state_r == S_SCAN) && (row_r < rows_need);

  // insert position and id of a new entry
  assign has_room = count_r < CW'(TABLE_DEPTH);
  assign new_id   = ID_W'(count_x + XW'(1));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    row_nxt   = row_r;
    sid_nxt   = sid_r;
    did_nxt   = did_r;
    full_nxt  = full_r;
    wr_en     = 1'b0;
    wr_data   = src_r;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
          row_nxt   = '0;
          full_nxt  = 1'b0;
        end
      end
      S_SCAN: begin
        if (rd_issue) begin
          row_nxt = row_r + XW'(1);
        end else if (!rd_vld_r) begin
          state_nxt = S_INS_SRC;
        end
      end
      S_INS_SRC: begin
        state_nxt = S_INS_DST;
        if (mres.src_found) begin
          sid_nxt = mres.src_id;
        end else if (has_room) begin
          wr_en     = 1'b1;
          sid_nxt   = new_id;
          count_nxt = count_r + CW'(1);
        end else begin
          sid_nxt  = '0;
          full_nxt = 1'b1;
        end
      end
      S_INS_DST: begin
        state_nxt = S_DONE;
        wr_data   = dst_r;
        if (mres.dst_found) begin
          did_nxt = mres.dst_id;
        end else if (dst_r == src_r) begin
          // source was just inserted (or refused), same outcome
          did_nxt = sid_r;
        end else if (has_room) begin
          wr_en     = 1'b1;
          did_nxt   = new_id;
          count_nxt = count_r + CW'(1);
        end else begin
          did_nxt  = '0;
          full_nxt = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // bank select for the write
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_wr[l] = wr_en && (count_x[LW-1:0] == LW'(l));
    end
  end

  // lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ipa_lane #(
      .RW       (RW),
      .LW       (LW),
      .XW       (XW),
      .LANE_IDX (g)
    ) u_lane (
      .clk      (clk),
      .rd_en    (rd_issue),
      .rd_row   (row_r[RW-1:0]),
      .rd_row_d (rd_row_r),
      .wr_en    (lane_wr[g]),
      .wr_row   (count_x[EW-1:LW]),
      .wr_data  (wr_data),
      .src_addr (src_r),
      .dst_addr (dst_r),
      .count_x  (count_x),
      .hit      (hits[g])
    );
  end

  ipa_merge #(
    .LANES (LANES),
    .RW    (RW),
    .LW    (LW)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (accept),
    .row_vld (rd_vld_r),
    .row     (rd_row_r),
    .hits    (hits),
    .res     (mres)
  );

  // time since previous packet, with microsecond borrow
  assign borrow = us_r < last_us_r;
  assign dsec   = sec_r - last_sec_r - SEC_W'(borrow);
  assign dus    = borrow ? US_W'(MICROS_PER_SEC - (US_W+1)'(last_us_r) + (US_W+1)'(us_r))
                         : us_r - last_us_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      row_r       <= '0;
      rd_vld_r    <= 1'b0;
      have_last_r <= 1'b0;
      last_sec_r  <= '0;
      last_us_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      row_r    <= row_nxt;
      rd_vld_r <= rd_issue;
      if (out_load) begin
        have_last_r <= 1'b1;
        last_sec_r  <= sec_r;
        last_us_r   <= us_r;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    rd_row_r <= row_r[RW-1:0];
    sid_r    <= sid_nxt;
    did_r    <= did_nxt;
    full_r   <= full_nxt;
    if (accept) begin
      src_r <= in_req.source_address;
      dst_r <= in_req.dest_address;
      sec_r <= in_req.stamp_seconds;
      us_r  <= (in_req.stamp_micros > MICROS_MAX) ? MICROS_MAX : in_req.stamp_micros;
    end
    if (out_load) begin
      out_sid_r   <= sid_r;
      out_did_r   <= did_r;
      out_full_r  <= full_r;
      out_first_r <= !have_last_r;
      out_dsec_r  <= have_last_r ? dsec : '0;
      out_dus_r   <= have_last_r ? dus : '0;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.source_id     = out_sid_r;
  assign out_res.dest_id       = out_did_r;
  assign out_res.delta_seconds = out_dsec_r;
  assign out_res.delta_micros  = out_dus_r;
  assign out_res.first_packet  = out_first_r;
  assign out_res.table_full    = out_full_r;

endmodule

// File: rtl/core/ipa_checker.sv
// ----------------------------------------------------------------------------
// ipa_checker
// Port-level checks of the address id assigner, bound to the top level.
// ----------------------------------------------------------------------------
module ipa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ipa_pkg::ID_W-1:0]         source_id,
  input logic [ipa_pkg::ID_W-1:0]         dest_id,
  input logic signed [ipa_pkg::SEC_W-1:0] delta_seconds,
  input logic [ipa_pkg::US_W-1:0]         delta_micros,
  input logic                             first_packet,
  input logic                             table_full
);
  import ipa_pkg::*;

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a full table shows as at least one id of zero
  a_full_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && table_full |-> (source_id == '0) || (dest_id == '0))
    else $error("table full without a zero id");

  // first packet carries zero deltas
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_packet |-> (delta_seconds == '0) && (delta_micros == '0))
    else $error("first packet with nonzero delta");

endmodule

bind ip_address_id_assigner_top ipa_checker u_ipa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .source_id     (out_res.source_id),
  .dest_id       (out_res.dest_id),
  .delta_seconds (out_res.delta_seconds),
  .delta_micros  (out_res.delta_micros),
  .first_packet  (out_res.first_packet),
  .table_full    (out_res.table_full)
);
